>>> design/sca_pkg.sv
package sca_pkg;

  localparam int DYN_CHANNELS_DEF = 8;

  localparam logic signed [3:0] ANY_CHAN = -4'sd1;
  localparam logic signed [3:0] NO_OVERRIDE_CHAN = 4'sd0;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_STOP     = 2'd1,
    OP_STOP_ALL = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STARTED = 3'd0,
    ST_SILENT  = 3'd1,
    ST_NOSLOT  = 3'd2,
    ST_STOPPED = 3'd3,
    ST_MISS    = 3'd4,
    ST_CLEARED = 3'd5,
    ST_TICK    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [9:0]         sound;
    logic [12:0]        entity;
    logic signed [3:0]  chan;
    logic [31:0]        end_time;
  } slot_entry_t;

  typedef struct packed {
    logic wr_en;
    logic clr_one;
    logic clr_all;
  } tbl_cmd_t;

  typedef struct packed {
    logic        hit;
    logic        skip;
    logic        better;
    logic [31:0] key;
  } scan_res_t;

endpackage

>>> design/sca_in_if.sv
interface sca_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [12:0]       entity;
  logic signed [3:0] ent_channel;
  logic [9:0]        sound_id;
  logic [23:0]       sound_length;
  logic              audible;
  logic [15:0]       time_advance;

  modport source (
    output valid, op, entity, ent_channel, sound_id, sound_length, audible, time_advance,
    input  ready
  );
  modport sink (
    input  valid, op, entity, ent_channel, sound_id, sound_length, audible, time_advance,
    output ready
  );
endinterface

>>> design/sca_out_if.sv
interface sca_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot;

  modport source (
    output valid, status, slot,
    input  ready
  );
  modport sink (
    input  valid, status, slot,
    output ready
  );
endinterface

>>> design/sca_table.sv
module sca_table #(
  parameter int N = sca_pkg::DYN_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [$clog2(N)-1:0]  rd_addr,
  output sca_pkg::slot_entry_t  rd_data,
  input  sca_pkg::tbl_cmd_t     cmd,
  input  logic [$clog2(N)-1:0]  wr_addr,
  input  sca_pkg::slot_entry_t  wr_data
);

  sca_pkg::slot_entry_t mem_r [N];
  sca_pkg::slot_entry_t rd_ent_r;
  logic [N-1:0]         vld_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_ent_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr_all) begin
        vld_r <= '0;
      end else if (cmd.clr_one) begin
        vld_r[wr_addr] <= 1'b0;
      end else if (cmd.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // empty slots read as all zero
  assign rd_data = rd_vld_r ? rd_ent_r : '0;

endmodule

>>> design/sca_scan_unit.sv
module sca_scan_unit (
  input  sca_pkg::slot_entry_t entry,
  input  logic                 is_start,
  input  logic [12:0]          req_entity,
  input  logic signed [3:0]    req_chan,
  input  logic [12:0]          view_entity,
  input  logic [31:0]          paint_time,
  input  logic [31:0]          best_key,
  output sca_pkg::scan_res_t   res
);

  logic same_ent;
  logic start_hit;
  logic stop_hit;

  always_comb begin
    same_ent  = (entry.entity == req_entity);
    start_hit = (req_chan != sca_pkg::NO_OVERRIDE_CHAN) && same_ent &&
                ((entry.chan == req_chan) || (req_chan == sca_pkg::ANY_CHAN));
    stop_hit  = same_ent && (entry.chan == req_chan);
    res.hit   = is_start ? start_hit : stop_hit;
    res.skip  = (entry.entity == view_entity) && (req_entity != view_entity) &&
                (entry.sound != '0);
    // signed remaining life, biased so an unsigned compare orders it
    res.key   = (entry.end_time - paint_time) ^ 32'h8000_0000;
    res.better = (res.key < best_key);
  end

endmodule

>>> design/sound_channel_allocator.sv
// Sound channel allocator: a table of N dynamic voice slots and a paint-time counter.
// in_ch carries one command item (start, stop, stop all, tick); out_ch returns one
// item per command with a status code and the slot picked or stopped. Both channels
// use valid/ready; an item moves at a clock edge with both high. cfg_we/cfg_wdata
// write the view entity at any edge with cfg_we high.
// Start and stop walk the slot table through one read port and one shared compare
// unit, one slot per cycle, each read registered before the compare, then commit in
// the done state; the walk ends early when a stop or takeover matches. Stop all and
// tick skip the walk and go straight to commit. One command is in flight at a time;
// in_ch.ready is high only while the sequencer is idle.
// Result is held in an output register; if out_ch stalls, the next command is still
// accepted and walked, then waits at its commit with in_ch not ready until the held
// item is taken.
// Reset (rst_n low, synchronous) empties all slots through per-slot valid bits,
// zeroes paint time and the view entity; no clearing pass is needed.
module sound_channel_allocator #(
  parameter int DYN_CHANNELS = sca_pkg::DYN_CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sca_in_if.sink       in_ch,
  sca_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [12:0]  cfg_wdata
);

  localparam int AW = $clog2(DYN_CHANNELS);
  localparam logic [AW:0]   NUM  = (AW+1)'(DYN_CHANNELS);
  localparam logic [AW-1:0] LAST = AW'(DYN_CHANNELS - 1);

  sca_pkg::fsm_t state_r, state_nxt;

  sca_pkg::op_t      req_op_r;
  logic [12:0]       req_ent_r;
  logic signed [3:0] req_chan_r;
  logic [9:0]        req_sid_r;
  logic [23:0]       req_len_r;
  logic              req_aud_r;
  logic [15:0]       req_adv_r;

  logic [12:0] view_r;
  logic [31:0] paint_r, paint_nxt;

  logic [AW:0]   idx_r, idx_nxt;
  logic          ev_valid_r, ev_valid_nxt;
  logic [AW-1:0] ev_idx_r, ev_idx_nxt;
  logic [31:0]   best_key_r, best_key_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic          found_r, found_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  sca_pkg::status_t  status_r, status_nxt;
  logic [2:0]        slot_r, slot_nxt;

  logic in_acc, rd_en, commit, out_free, scan_done;

  sca_pkg::slot_entry_t rd_data, wr_data;
  sca_pkg::tbl_cmd_t    cmd;
  logic [AW-1:0]        wr_addr;
  sca_pkg::scan_res_t   res;

  sca_table #(.N(DYN_CHANNELS)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sca_scan_unit u_scan (
    .entry       (rd_data),
    .is_start    (req_op_r == sca_pkg::OP_START),
    .req_entity  (req_ent_r),
    .req_chan    (req_chan_r),
    .view_entity (view_r),
    .paint_time  (paint_r),
    .best_key    (best_key_r),
    .res         (res)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign scan_done = ev_valid_r && (res.hit || (ev_idx_r == LAST));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sca_pkg::S_IDLE: begin
        if (in_acc) begin
          if (sca_pkg::op_t'(in_ch.op) == sca_pkg::OP_START ||
              sca_pkg::op_t'(in_ch.op) == sca_pkg::OP_STOP) begin
            state_nxt = sca_pkg::S_SCAN;
          end else begin
            state_nxt = sca_pkg::S_DONE;
          end
        end
      end
      sca_pkg::S_SCAN: begin
        if (scan_done) state_nxt = sca_pkg::S_DONE;
      end
      sca_pkg::S_DONE: begin
        if (out_free) state_nxt = sca_pkg::S_IDLE;
      end
      default: state_nxt = sca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == sca_pkg::S_IDLE);
    rd_en       = (state_r == sca_pkg::S_SCAN) && (idx_r < NUM);
    commit      = (state_r == sca_pkg::S_DONE) && out_free;
  end

  always_comb begin
    idx_nxt       = idx_r;
    ev_valid_nxt  = ev_valid_r;
    ev_idx_nxt    = ev_idx_r;
    best_key_nxt  = best_key_r;
    best_idx_nxt  = best_idx_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    paint_nxt     = paint_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    cmd           = '0;
    wr_addr       = hit_idx_r;
    wr_data.sound    = req_aud_r ? req_sid_r : '0;
    wr_data.entity   = req_ent_r;
    wr_data.chan     = req_chan_r;
    wr_data.end_time = req_aud_r ? (paint_r + 32'(req_len_r)) : '0;

    if (in_acc) begin
      idx_nxt      = '0;
      ev_valid_nxt = 1'b0;
      best_key_nxt = '1;
      found_nxt    = 1'b0;
      hit_nxt      = 1'b0;
    end

    if (state_r == sca_pkg::S_SCAN) begin
      if (rd_en) idx_nxt = idx_r + 1'b1;
      ev_valid_nxt = rd_en;
      ev_idx_nxt   = idx_r[AW-1:0];
      if (ev_valid_r && !hit_r) begin
        if (res.hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = ev_idx_r;
        end else if (req_op_r == sca_pkg::OP_START && !res.skip && res.better) begin
          best_key_nxt = res.key;
          best_idx_nxt = ev_idx_r;
          found_nxt    = 1'b1;
        end
      end
    end

    if (commit) begin
      out_valid_nxt = 1'b1;
      slot_nxt      = '0;
      case (req_op_r)
        sca_pkg::OP_START: begin
          wr_addr = hit_r ? hit_idx_r : best_idx_r;
          if (hit_r || found_r) begin
            cmd.wr_en  = 1'b1;
            slot_nxt   = 3'(wr_addr);
            status_nxt = req_aud_r ? sca_pkg::ST_STARTED : sca_pkg::ST_SILENT;
          end else begin
            status_nxt = sca_pkg::ST_NOSLOT;
          end
        end
        sca_pkg::OP_STOP: begin
          if (hit_r) begin
            cmd.clr_one = 1'b1;
            slot_nxt    = 3'(hit_idx_r);
            status_nxt  = sca_pkg::ST_STOPPED;
          end else begin
            status_nxt = sca_pkg::ST_MISS;
          end
        end
        sca_pkg::OP_STOP_ALL: begin
          cmd.clr_all = 1'b1;
          status_nxt  = sca_pkg::ST_CLEARED;
        end
        sca_pkg::OP_TICK: begin
          paint_nxt  = paint_r + 32'(req_adv_r);
          status_nxt = sca_pkg::ST_TICK;
        end
        default: status_nxt = sca_pkg::ST_TICK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sca_pkg::S_IDLE;
      view_r      <= '0;
      paint_r     <= '0;
      idx_r       <= '0;
      ev_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) view_r <= cfg_wdata;
      paint_r     <= paint_nxt;
      idx_r       <= idx_nxt;
      ev_valid_r  <= ev_valid_nxt;
      found_r     <= found_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op_r   <= sca_pkg::op_t'(in_ch.op);
      req_ent_r  <= in_ch.entity;
      req_chan_r <= in_ch.ent_channel;
      req_sid_r  <= in_ch.sound_id;
      req_len_r  <= in_ch.sound_length;
      req_aud_r  <= in_ch.audible;
      req_adv_r  <= in_ch.time_advance;
    end
    ev_idx_r   <= ev_idx_nxt;
    best_key_r <= best_key_nxt;
    best_idx_r <= best_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.slot   = slot_r;

endmodule

>>> design/sca_checker.sv
module sca_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [2:0] out_slot
);

  // one command in flight: not ready right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command is in flight");

  // slot is zero for results that carry no slot
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sca_pkg::ST_NOSLOT || out_status == sca_pkg::ST_MISS ||
                  out_status == sca_pkg::ST_CLEARED || out_status == sca_pkg::ST_TICK)
    |-> (out_slot == 3'd0))
    else $error("nonzero slot on a result without a slot");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_status) && $stable(out_slot)))
    else $error("result changed while stalled");

endmodule

bind sound_channel_allocator sca_checker u_sca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot)
);
